// ===== src/pidmsc_pkg.sv =====
// Shared types, constants and register codes for the PID motor speed controller.
package pidmsc_pkg;

  localparam int SPEED_W   = 14;
  localparam int TARGET_W  = 15;
  localparam int ERR_W     = 16;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int GAIN_W    = 24;
  localparam int RUN_W     = 16;
  localparam int DUTY_W    = 9;
  localparam int MAG_W     = 8;
  localparam int DIR_W     = 2;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 24;
  localparam int FRAC_BITS = 16;

  localparam int SUM_BITS  = 32;
  localparam int DUTY_MAX  = 255;
  localparam int GLITCH_RPM = 7000;

  localparam int P_W   = ERR_W + GAIN_W;
  localparam int D_W   = DIFF_W + GAIN_W;
  localparam int I_W   = SUM_BITS + GAIN_W;
  localparam int TOT_W = I_W + 2;
  localparam int U_W   = TOT_W - FRAC_BITS;

  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(3277);
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(655);
  localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = '0;
  localparam logic [RUN_W-1:0]         REV_LIMIT_RST  = RUN_W'(5);

  typedef enum logic [IDX_W-1:0] {
    REG_RPM_MODE      = 3'd0,
    REG_GAIN_PROP     = 3'd1,
    REG_GAIN_INTEG    = 3'd2,
    REG_GAIN_DERIV    = 3'd3,
    REG_TARGET_SPEED  = 3'd4,
    REG_REVERSE_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    logic                       rpm_mode;
    logic signed [GAIN_W-1:0]   gain_prop;
    logic signed [GAIN_W-1:0]   gain_integ;
    logic signed [GAIN_W-1:0]   gain_deriv;
    logic signed [TARGET_W-1:0] target_speed;
    logic [RUN_W-1:0]           reverse_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] duty;
    logic [DIR_W-1:0]         direction;
    logic [MAG_W-1:0]         magnitude;
    logic                     duty_changed;
  } result_t;

endpackage

// ===== src/pidmsc_cfg.sv =====
// Configuration register file with the target-change clear pulse.
module pidmsc_cfg import pidmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  output cfg_t              cfg,
  output logic              sum_clr
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    sum_clr = 1'b0;
    if (wr_en) begin
      unique case (wr_index)
        REG_RPM_MODE:      cfg_nxt.rpm_mode      = wr_data[0];
        REG_GAIN_PROP:     cfg_nxt.gain_prop     = $signed(wr_data[GAIN_W-1:0]);
        REG_GAIN_INTEG:    cfg_nxt.gain_integ    = $signed(wr_data[GAIN_W-1:0]);
        REG_GAIN_DERIV:    cfg_nxt.gain_deriv    = $signed(wr_data[GAIN_W-1:0]);
        REG_TARGET_SPEED: begin
          cfg_nxt.target_speed = $signed(wr_data[TARGET_W-1:0]);
          sum_clr = (wr_data[TARGET_W-1:0] != cfg_r.target_speed);
        end
        REG_REVERSE_LIMIT: cfg_nxt.reverse_limit = wr_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rpm_mode      <= 1'b0;
      cfg_r.gain_prop     <= GAIN_PROP_RST;
      cfg_r.gain_integ    <= GAIN_INTEG_RST;
      cfg_r.gain_deriv    <= GAIN_DERIV_RST;
      cfg_r.target_speed  <= '0;
      cfg_r.reverse_limit <= REV_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/pidmsc_core.sv =====
// Loop state and combinational PID datapath with clamp and reverse cutoff.
module pidmsc_core import pidmsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               sum_clr,
  input  logic               fire,
  input  logic [SPEED_W-1:0] speed,
  output result_t            res
);

  logic signed [SUM_BITS-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0]    last_error_r;
  logic [SPEED_W-1:0]         last_good_r, last_good_nxt;
  logic [RUN_W-1:0]           neg_run_r, neg_run_nxt, run_inc;
  logic signed [DUTY_W-1:0]   applied_r, applied_nxt;

  logic [SPEED_W-1:0]         speed_use;
  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [P_W-1:0]      p_prod;
  logic signed [I_W-1:0]      i_prod;
  logic signed [D_W-1:0]      d_prod;
  logic signed [TOT_W-1:0]    total, total_bias;
  logic signed [U_W-1:0]      drive;
  logic signed [SUM_BITS:0]   sum_ext;
  logic                       neg;
  logic signed [DUTY_W-1:0]   duty_new, duty_out;
  logic [DUTY_W-1:0]          duty_abs;
  logic                       step;

  assign step = fire && cfg.rpm_mode;

  always_comb begin
    if (speed > SPEED_W'(GLITCH_RPM)) begin
      speed_use     = last_good_r;
      last_good_nxt = last_good_r;
    end else begin
      speed_use     = speed;
      last_good_nxt = speed;
    end
  end

  assign err = $signed({cfg.target_speed[TARGET_W-1], cfg.target_speed})
             - $signed({{(ERR_W-SPEED_W){1'b0}}, speed_use});
  assign diff = $signed({err[ERR_W-1], err}) - $signed({last_error_r[ERR_W-1], last_error_r});

  assign p_prod = P_W'(err) * P_W'(cfg.gain_prop);
  assign i_prod = I_W'(error_sum_r) * I_W'(cfg.gain_integ);
  assign d_prod = D_W'(diff) * D_W'(cfg.gain_deriv);

  assign total = TOT_W'(p_prod) + TOT_W'(i_prod) + TOT_W'(d_prod);
  assign total_bias = total
                    + $signed({{(TOT_W-FRAC_BITS){1'b0}}, {FRAC_BITS{total[TOT_W-1]}}});
  assign drive = total_bias[TOT_W-1:FRAC_BITS];
  assign neg   = drive[U_W-1];

  assign run_inc     = (neg_run_r != '1) ? neg_run_r + RUN_W'(1) : neg_run_r;
  assign neg_run_nxt = neg ? run_inc : '0;

  always_comb begin
    if (!neg) begin
      if (drive > $signed(U_W'(DUTY_MAX))) begin
        duty_new = DUTY_W'(DUTY_MAX);
      end else begin
        duty_new = drive[DUTY_W-1:0];
      end
    end else if (run_inc > cfg.reverse_limit) begin
      duty_new = '0;
    end else if (drive < -$signed(U_W'(DUTY_MAX))) begin
      duty_new = -$signed(DUTY_W'(DUTY_MAX));
    end else begin
      duty_new = drive[DUTY_W-1:0];
    end
  end

  always_comb begin
    sum_ext = $signed({error_sum_r[SUM_BITS-1], error_sum_r})
            + $signed({{(SUM_BITS+1-ERR_W){err[ERR_W-1]}}, err});
    if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
      error_sum_nxt = sum_ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                        : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      error_sum_nxt = sum_ext[SUM_BITS-1:0];
    end
  end

  assign applied_nxt = duty_new;
  assign duty_out    = cfg.rpm_mode ? duty_new : applied_r;
  assign duty_abs    = duty_out[DUTY_W-1] ? DUTY_W'(-duty_out) : DUTY_W'(duty_out);

  always_comb begin
    res.duty         = duty_out;
    res.magnitude    = duty_abs[MAG_W-1:0];
    res.duty_changed = cfg.rpm_mode && (duty_new != applied_r);
    if (duty_out == '0) begin
      res.direction = DIR_STOP;
    end else if (duty_out[DUTY_W-1]) begin
      res.direction = DIR_REV;
    end else begin
      res.direction = DIR_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
      last_good_r  <= '0;
      neg_run_r    <= '0;
      applied_r    <= '0;
    end else if (sum_clr) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (step) begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= err;
      last_good_r  <= last_good_nxt;
      neg_run_r    <= neg_run_nxt;
      applied_r    <= applied_nxt;
    end
  end

endmodule

// ===== src/pid_motor_speed_control.sv =====
// Top level of the PID motor speed controller: handshake registers around the datapath.
// The block takes one speed word per clock cycle while in_stall is low, and returns
// one result word for each. An accepted speed word is captured in the input register
// and then passes through the PID datapath (three parallel multiplies, the sum, the
// clamp) into the output register when the output register is free to advance.
// The loop state is updated at the edge that loads the output register, so every word
// sees the state left by the word before it. in_stall rises only while both registers
// hold words and out_stall is high. cfg_ready is always high; write configuration only
// while no word is in flight. With rpm mode off, words pass through and report the held
// duty without touching the loop state.
module pid_motor_speed_control import pidmsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SPEED_W-1:0]       in_measured_speed,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DUTY_W-1:0] out_duty,
  output logic [DIR_W-1:0]         out_direction,
  output logic [MAG_W-1:0]         out_magnitude,
  output logic                     out_duty_changed,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  cfg_t               cfg;
  logic               sum_clr;
  logic               in_valid_r;
  logic [SPEED_W-1:0] speed_r;
  logic               out_valid_r;
  result_t            res;
  result_t            res_r;
  logic               adv;
  logic               fire;

  assign cfg_ready = 1'b1;

  pidmsc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .sum_clr  (sum_clr)
  );

  pidmsc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .sum_clr (sum_clr),
    .fire    (fire),
    .speed   (speed_r),
    .res     (res)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      speed_r <= in_measured_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = res_r.duty;
  assign out_direction    = res_r.direction;
  assign out_magnitude    = res_r.magnitude;
  assign out_duty_changed = res_r.duty_changed;

endmodule

// ===== src/pidmsc_checker.sv =====
// Port-level checker for the PID motor speed controller and its bind.
module pidmsc_checker import pidmsc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [SPEED_W-1:0]       in_measured_speed,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DUTY_W-1:0] out_duty,
  input logic [DIR_W-1:0]         out_direction,
  input logic [MAG_W-1:0]         out_magnitude,
  input logic                     out_duty_changed
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_measured_speed))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty) && $stable(out_duty_changed))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output could move");

  a_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_direction == DIR_STOP) == (out_duty == '0))
                  && ((out_direction == DIR_REV) == (out_duty < 0))
                  && (out_direction != 2'd3))
    else $error("direction does not match duty");

  a_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty != $signed({1'b1, {(DUTY_W-1){1'b0}}}))
                  && (out_magnitude == (out_duty[DUTY_W-1] ? MAG_W'(-out_duty)
                                                           : out_duty[MAG_W-1:0])))
    else $error("magnitude does not match duty");

endmodule

bind pid_motor_speed_control pidmsc_checker u_pidmsc_checker (.*);
